// File: hw/rtl/pptb_pkg.sv
package pptb_pkg;

	localparam logic [1:0] CMD_CHECK  = 2'd0;
	localparam logic [1:0] CMD_SENT   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_NUM    = 3'd1;
	localparam logic [2:0] REG_DEN    = 3'd2;
	localparam logic [2:0] REG_BURST  = 3'd3;
	localparam logic [2:0] REG_GRAN   = 3'd4;

	localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
	localparam logic [15:0] RTT_MAX_MS = 16'd60000;
	localparam logic [31:0] MS_PER_SEC = 32'd1000;
	localparam logic [62:0] MAX63      = {63{1'b1}};
	localparam int          SAT_BITS   = 28;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_M_BURST, S_M_DEN, S_M_K, S_M_NUM, S_RATE, S_RATE_W,
		S_REFILL, S_EL_W, S_RW_W, S_M_A, S_M_B, S_M_C, S_M_D, S_FR_W,
		S_UPDATE, S_DECIDE, S_W_NUM, S_W_DIV, S_G_DIV, S_EMIT
	} state_t;

	// clamp to 2^28; the result feeds sums and products that end in a compare against a sub-2^27 value
	function automatic logic [SAT_BITS:0] sat28(input logic [63:0] x);
		logic [SAT_BITS:0] r;
		if (x >= 64'(1) << SAT_BITS) begin
			r = (SAT_BITS+1)'(1) << SAT_BITS;
		end else begin
			r = x[SAT_BITS:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/packet_pacer_token_bucket.sv
// channel | dir | handshake         | payload
// s       | in  | s_tvalid/s_tready | tuser: cmd; tdata: now_ns, cwnd, rtt, mtu, sent
// m       | out | m_tvalid/m_tready | tdata: may_send, release_time_ns
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
// A check makes up to six passes through one shared divider (2 quotient bits a
// cycle) plus steps of one shared 32x32 multiplier. Sent and clear commands end in
// the dispatch state; a disabled check goes straight to emit. s_tready is high only
// while idle. A result waits in the output register while m_tready is low; the block
// holds before loading the next one.
// arst_n clears the pacer state and loads the register defaults; cfg is always ready.
module packet_pacer_token_bucket import pptb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [1:0]   s_tuser,   // [1:0] cmd
	input  logic [159:0] s_tdata,   // now_ns[62:0], cwnd_bytes, avg_rtt_ms, mtu, sent_bytes
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // may_send[0], release_time_ns[63:1]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [19:0]  cfg_data
);

	state_t state_q, state_d;

	logic        en_q;
	logic [15:0] rnum_q, rden_q;
	logic [10:0] bp_q;
	logic [19:0] gran_q;

	logic [1:0]  cmd_q;
	logic [62:0] now_q;
	logic [31:0] cwnd_q, rtt_q;
	logic [15:0] mtu_q, sent_q;

	logic        started_q;
	logic [62:0] last_q;
	logic [26:0] budget_q, cap_q, capn_q;
	logic [63:0] rate_q, rate_new_q;
	logic [29:0] frac_q;

	logic [31:0] den_q;
	logic [33:0] ewhole_q;
	logic [29:0] erem_q, rrem_q;
	logic [28:0] rwhole_q;
	logic [29:0] acc_q;
	logic [48:0] wait_q;
	logic        res_may_q;
	logic [62:0] res_rel_q;

	logic        out_valid_q, out_may_q;
	logic [62:0] out_rel_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p_q;

	logic        dv_go, dv_busy_q;
	logic [63:0] dv_a, dv_b, dv_rem_q, dv_quo_q, dv_den_q, dv_rem_n, dv_quo_n;
	logic [4:0]  dv_cnt_q;

	logic [15:0] mtu_adj, rtt_c, deficit;
	logic [31:0] win;
	logic [29:0] quantum;
	logic [26:0] burst_min, cap_calc;
	logic        refill_go;
	logic [63:0] fracn, wnum, wt, w2, rel_sum;
	logic [29:0] added;
	logic [26:0] needed;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {out_rel_q, out_may_q};

	// operand conditioning
	always_comb begin
		mtu_adj = (mtu_q == 16'd0) ? 16'd1 : mtu_q;
		win     = (cwnd_q > 32'(mtu_adj)) ? cwnd_q : 32'(mtu_adj);
		if (rtt_q == 32'd0) begin
			rtt_c = 16'd1;
		end else if (rtt_q > 32'(RTT_MAX_MS)) begin
			rtt_c = RTT_MAX_MS;
		end else begin
			rtt_c = rtt_q[15:0];
		end
		quantum   = (30'(gran_q) << 10) - (30'(gran_q) << 4) - (30'(gran_q) << 3);
		burst_min = (32'(mul_p_q[26:0]) < win) ? mul_p_q[26:0] : win[26:0];
		cap_calc  = (burst_min < 27'(mtu_adj)) ? 27'(mtu_adj) : burst_min;
		refill_go = started_q && (now_q > last_q) && (budget_q < cap_q);
		deficit   = mtu_adj - budget_q[15:0];
		fracn     = mul_p_q + 64'(frac_q);
		wnum      = (mul_p_q > 64'(frac_q)) ? (mul_p_q - 64'(frac_q)) : 64'd1;
		wt        = dv_quo_q + 64'(dv_rem_q != 64'd0);
		w2        = (dv_rem_q == 64'd0) ? 64'(wait_q)
		            : (64'(wait_q) - dv_rem_q + 64'(quantum));
		rel_sum   = 64'(now_q) + ((state_q == S_G_DIV) ? w2 : wt);
		added     = acc_q + 30'(sat28(dv_quo_q));
		needed    = cap_q - budget_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (s_tvalid) state_d = S_DISP;
			S_DISP: begin
				if (cmd_q != CMD_CHECK) begin
					state_d = S_IDLE;
				end else if (!en_q) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_M_BURST;
				end
			end
			S_M_BURST: state_d = S_M_DEN;
			S_M_DEN:   state_d = S_M_K;
			S_M_K:     state_d = S_M_NUM;
			S_M_NUM:   state_d = S_RATE;
			S_RATE:    state_d = (den_q == 32'd0) ? S_REFILL : S_RATE_W;
			S_RATE_W:  if (!dv_busy_q) state_d = S_REFILL;
			S_REFILL:  state_d = refill_go ? S_EL_W : S_UPDATE;
			S_EL_W:    if (!dv_busy_q) state_d = S_RW_W;
			S_RW_W:    if (!dv_busy_q) state_d = S_M_A;
			S_M_A:     state_d = S_M_B;
			S_M_B:     state_d = S_M_C;
			S_M_C:     state_d = S_M_D;
			S_M_D:     state_d = S_FR_W;
			S_FR_W:    if (!dv_busy_q) state_d = S_UPDATE;
			S_UPDATE:  state_d = S_DECIDE;
			S_DECIDE:  state_d = (budget_q >= 27'(mtu_adj)) ? S_EMIT : S_W_NUM;
			S_W_NUM:   state_d = S_W_DIV;
			S_W_DIV: begin
				if (!dv_busy_q) state_d = (gran_q != 20'd0) ? S_G_DIV : S_EMIT;
			end
			S_G_DIV:   if (!dv_busy_q) state_d = S_EMIT;
			S_EMIT:    if (!out_valid_q || m_tready) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// shared unit operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		dv_go = 1'b0;
		dv_a  = '0;
		dv_b  = '0;
		unique case (state_q)
			S_M_BURST: begin mul_a = 32'(mtu_adj); mul_b = 32'(bp_q); end
			S_M_DEN:   begin mul_a = 32'(rtt_c); mul_b = 32'(rden_q); end
			S_M_K:     begin mul_a = 32'(rnum_q); mul_b = MS_PER_SEC; end
			S_M_NUM:   begin mul_a = win; mul_b = mul_p_q[31:0]; end
			S_RATE: begin
				dv_go = (den_q != 32'd0);
				dv_a  = mul_p_q;
				dv_b  = 64'(den_q);
			end
			S_REFILL: begin
				dv_go = refill_go;
				dv_a  = 64'(now_q - last_q);
				dv_b  = NS_PER_SEC;
			end
			S_EL_W: begin
				dv_go = !dv_busy_q;
				dv_a  = rate_q;
				dv_b  = NS_PER_SEC;
			end
			S_M_A: begin
				mul_a = 32'(sat28(64'(ewhole_q)));
				mul_b = 32'(sat28(rate_q));
			end
			S_M_B: begin mul_a = 32'(erem_q); mul_b = 32'(rwhole_q); end
			S_M_C: begin mul_a = 32'(erem_q); mul_b = 32'(rrem_q); end
			S_M_D: begin
				dv_go = 1'b1;
				dv_a  = fracn;
				dv_b  = NS_PER_SEC;
			end
			S_DECIDE: begin mul_a = 32'(deficit); mul_b = NS_PER_SEC[31:0]; end
			S_W_NUM: begin
				dv_go = 1'b1;
				dv_a  = wnum;
				dv_b  = rate_q;
			end
			S_W_DIV: begin
				dv_go = !dv_busy_q && (gran_q != 20'd0);
				dv_a  = wt;
				dv_b  = 64'(quantum);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_p_q <= 64'(mul_a) * 64'(mul_b);
	end

	// radix-4 restoring divide step
	always_comb begin
		logic [64:0] r2;
		dv_rem_n = dv_rem_q;
		dv_quo_n = dv_quo_q;
		for (int i = 0; i < 2; i++) begin
			r2       = {dv_rem_n, dv_quo_n[63]};
			dv_quo_n = dv_quo_n << 1;
			if (r2 >= {1'b0, dv_den_q}) begin
				dv_rem_n    = 64'(r2 - {1'b0, dv_den_q});
				dv_quo_n[0] = 1'b1;
			end else begin
				dv_rem_n = r2[63:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_cnt_q  <= '0;
		end else if (dv_go) begin
			dv_busy_q <= 1'b1;
			dv_cnt_q  <= '0;
		end else if (dv_busy_q) begin
			dv_cnt_q <= dv_cnt_q + 5'd1;
			if (dv_cnt_q == 5'd31) dv_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_go) begin
			dv_rem_q <= '0;
			dv_quo_q <= dv_a;
			dv_den_q <= dv_b;
		end else if (dv_busy_q) begin
			dv_rem_q <= dv_rem_n;
			dv_quo_q <= dv_quo_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b1;
			rnum_q <= 16'd5;
			rden_q <= 16'd4;
			bp_q   <= 11'd10;
			gran_q <= 20'd1000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ENABLE: en_q   <= cfg_data[0];
				REG_NUM:    rnum_q <= cfg_data[15:0];
				REG_DEN:    rden_q <= cfg_data[15:0];
				REG_BURST:  bp_q   <= cfg_data[10:0];
				REG_GRAN:   gran_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			started_q   <= 1'b0;
			last_q      <= '0;
			budget_q    <= '0;
			cap_q       <= '0;
			rate_q      <= '0;
			frac_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EMIT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_DISP: begin
					if (cmd_q == CMD_CLEAR) begin
						started_q <= 1'b0;
						last_q    <= '0;
						budget_q  <= '0;
						cap_q     <= '0;
						rate_q    <= '0;
						frac_q    <= '0;
					end else if (cmd_q == CMD_SENT && started_q && sent_q != 16'd0) begin
						budget_q <= (27'(sent_q) >= budget_q) ? 27'd0
						            : budget_q - 27'(sent_q);
					end
				end
				S_REFILL: begin
					if (!started_q) begin
						started_q <= 1'b1;
						last_q    <= now_q;
						budget_q  <= capn_q;
					end else if (now_q > last_q && budget_q >= cap_q) begin
						last_q <= now_q;
						frac_q <= '0;
					end
				end
				S_FR_W: begin
					if (!dv_busy_q) begin
						last_q <= now_q;
						if (added >= 30'(needed)) begin
							budget_q <= cap_q;
							frac_q   <= '0;
						end else begin
							budget_q <= budget_q + added[26:0];
							frac_q   <= dv_rem_q[29:0];
						end
					end
				end
				S_UPDATE: begin
					cap_q  <= capn_q;
					rate_q <= rate_new_q;
					if (budget_q > capn_q) budget_q <= capn_q;
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_q  <= s_tuser;
			now_q  <= s_tdata[62:0];
			cwnd_q <= s_tdata[94:63];
			rtt_q  <= s_tdata[126:95];
			mtu_q  <= s_tdata[142:127];
			sent_q <= s_tdata[158:143];
		end
		if (state_q == S_EMIT && (!out_valid_q || m_tready)) begin
			out_may_q <= res_may_q;
			out_rel_q <= res_rel_q;
		end
		unique case (state_q)
			S_DISP: begin
				res_may_q <= 1'b1;
				res_rel_q <= now_q;
			end
			S_M_DEN: capn_q <= cap_calc;
			S_M_K:   den_q  <= mul_p_q[31:0];
			S_RATE:  if (den_q == 32'd0) rate_new_q <= 64'd1;
			S_RATE_W: begin
				if (!dv_busy_q) rate_new_q <= (dv_quo_q == 64'd0) ? 64'd1 : dv_quo_q;
			end
			S_EL_W: begin
				if (!dv_busy_q) begin
					ewhole_q <= dv_quo_q[33:0];
					erem_q   <= dv_rem_q[29:0];
				end
			end
			S_RW_W: begin
				if (!dv_busy_q) begin
					rwhole_q <= dv_quo_q[28:0];
					rrem_q   <= dv_rem_q[29:0];
				end
			end
			S_M_B: acc_q <= 30'(sat28(mul_p_q));
			S_M_C: acc_q <= acc_q + 30'(sat28(mul_p_q));
			S_DECIDE: begin
				res_may_q <= (budget_q >= 27'(mtu_adj));
				res_rel_q <= now_q;
			end
			S_W_DIV: begin
				if (!dv_busy_q) begin
					wait_q    <= wt[48:0];
					res_may_q <= 1'b0;
					res_rel_q <= rel_sum[63] ? MAX63 : rel_sum[62:0];
				end
			end
			S_G_DIV: begin
				if (!dv_busy_q) begin
					res_rel_q <= rel_sum[63] ? MAX63 : rel_sum[62:0];
				end
			end
			default: ;
		endcase
	end

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		dv_go |-> !dv_busy_q) else $error("divider restarted while busy");

	a_budget_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (budget_q <= cap_q)) else $error("budget above capacity");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		64'(frac_q) < NS_PER_SEC) else $error("refill remainder out of range");

	a_rate_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && started_q) |-> (rate_q != 64'd0))
		else $error("zero rate after start");

endmodule

// File: tb/packet_pacer_token_bucket_tb.sv
module packet_pacer_token_bucket_tb;
	import pptb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] ALL64 = {64{1'b1}};
	localparam logic [63:0] TOP63 = {1'b0, {63{1'b1}}};

	typedef struct packed {
		logic [1:0]  cmd;
		logic [62:0] now_ns;
		logic [31:0] cwnd;
		logic [31:0] rtt;
		logic [15:0] mtu;
		logic [15:0] sent;
	} cmd_word_t;

	typedef struct packed {
		logic        may_send;
		logic [62:0] release_ns;
	} decision_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [1:0]   s_tuser = '0;
	logic [159:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [19:0]  cfg_data = '0;

	packet_pacer_token_bucket dut (.*);

	cmd_word_t pend_q[$];
	decision_t decision_q[$];
	int        mismatches = 0;
	int        n_checks = 0, n_grants = 0, n_waits = 0, n_cmds = 0;
	logic      in_fire = 1'b0;

	// mirror of the block's registers and pacer state
	logic        pace_en = 1'b1;
	logic [15:0] gain_num = 16'd5, gain_den = 16'd4;
	logic [10:0] burst_pk = 11'd10;
	logic [19:0] gran_us = 20'd1000;
	logic        started = 1'b0;
	logic [63:0] last_ns = '0, budget = '0, capacity = '0, rate_bps = '0, frac_acc = '0;

	initial forever #5 clk = ~clk;
	initial begin
		#30_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [63:0] mul_sat(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return (p[127:64] != 0) ? ALL64 : p[63:0];
	endfunction

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		return (a > ALL64 - b) ? ALL64 : a + b;
	endfunction

	function automatic logic [63:0] div_ceil(input logic [63:0] n, input logic [63:0] d);
		if (d == 0) return ALL64;
		return n / d + 64'((n % d) != 0);
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic top_up(input logic [63:0] now);
		logic [63:0] el, ew, er, rw, rr, added, f, need;
		if (now <= last_ns) return;
		if (budget >= capacity) begin
			last_ns = now;
			frac_acc = 0;
			return;
		end
		el = now - last_ns;
		last_ns = now;
		ew = el / NS_PER_SEC;
		er = el % NS_PER_SEC;
		rw = rate_bps / NS_PER_SEC;
		rr = rate_bps % NS_PER_SEC;
		added = mul_sat(ew, rate_bps);
		added = add_sat(added, mul_sat(er, rw));
		f = er * rr + frac_acc;
		added = add_sat(added, f / NS_PER_SEC);
		need = capacity - budget;
		if (added >= need) begin
			budget = capacity;
			frac_acc = 0;
		end else begin
			budget = budget + added;
			frac_acc = f % NS_PER_SEC;
		end
	endtask

	task automatic pace_decision(input cmd_word_t w);
		logic [63:0] now, mtu, win, brst, cap, rtt, den, rate, wnum, wait_ns, q;
		decision_t d;
		now = {1'b0, w.now_ns};
		if (w.cmd == CMD_CLEAR) begin
			started = 0; last_ns = 0; budget = 0; capacity = 0; rate_bps = 0; frac_acc = 0;
			return;
		end
		if (w.cmd == CMD_SENT) begin
			if (started && w.sent != 0)
				budget = (64'(w.sent) >= budget) ? 64'd0 : budget - 64'(w.sent);
			return;
		end
		if (w.cmd != CMD_CHECK) return;
		n_checks++;
		if (!pace_en) begin
			d.may_send = 1'b1;
			d.release_ns = w.now_ns;
			decision_q.push_back(d);
			return;
		end
		mtu = (w.mtu == 0) ? 64'd1 : 64'(w.mtu);
		win = (64'(w.cwnd) > mtu) ? 64'(w.cwnd) : mtu;
		brst = mtu * 64'(burst_pk);
		cap = (win < brst) ? win : brst;
		if (cap < mtu) cap = mtu;
		rtt = 64'(w.rtt);
		if (rtt < 1) rtt = 1;
		if (rtt > 64'(RTT_MAX_MS)) rtt = 64'(RTT_MAX_MS);
		den = rtt * 64'(gain_den);
		rate = (den != 0) ? (win * 64'(gain_num) * 64'(MS_PER_SEC)) / den : 64'd0;
		if (rate < 1) rate = 1;
		if (!started) begin
			last_ns = now; budget = cap; capacity = cap; rate_bps = rate; started = 1;
		end else begin
			top_up(now);
			capacity = cap;
			rate_bps = rate;
			if (budget > cap) budget = cap;
		end
		if (budget >= mtu) begin
			d.may_send = 1'b1;
			d.release_ns = w.now_ns;
		end else begin
			wnum = (mtu - budget) * NS_PER_SEC;
			wnum = (wnum > frac_acc) ? wnum - frac_acc : 64'd1;
			wait_ns = div_ceil(wnum, rate_bps);
			if (wait_ns < 1) wait_ns = 1;
			if (gran_us != 0) begin
				q = 64'(gran_us) * 64'd1000;
				wait_ns = mul_sat(div_ceil(wait_ns, q), q);
			end
			if (wait_ns > TOP63) wait_ns = TOP63;
			d.may_send = 1'b0;
			d.release_ns = (wait_ns > TOP63 - now) ? MAX63 : 63'(now + wait_ns);
		end
		decision_q.push_back(d);
	endtask

	// input side: accept, predict; output side: compare against oldest decision
	always @(posedge clk) begin
		decision_t d;
		in_fire <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			n_cmds++;
			pace_decision(cmd_word_t'({s_tuser, s_tdata[62:0], s_tdata[94:63],
				s_tdata[126:95], s_tdata[142:127], s_tdata[158:143]}));
		end
		if (m_tvalid && m_tready) begin
			if (decision_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", m_tdata);
			end else begin
				d = decision_q.pop_front();
				if (d.may_send ? m_tdata[0] : 1'b0) n_grants++;
				if (!d.may_send) n_waits++;
				if (m_tdata[0] !== d.may_send || m_tdata[63:1] !== d.release_ns) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: may_send exp %b got %b, release exp %0d got %0d",
							d.may_send, m_tdata[0], d.release_ns, m_tdata[63:1]);
				end
			end
		end
	end

	// sender: bursts with gaps
	int burst_left = 4, gap_left = 0;
	always @(negedge clk) begin
		cmd_word_t w;
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (gap_left > 0 || pend_q.size() == 0) begin
				s_tvalid <= 1'b0;
				if (gap_left > 0) gap_left--;
			end else begin
				w = pend_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= w.cmd;
				s_tdata <= {1'b0, w.sent, w.mtu, w.rtt, w.cwnd, w.now_ns};
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// receiver: stall mode switches among always ready, random ready and mostly stalled
	int rx_mode = 0, rx_cnt = 0;
	always @(negedge clk) begin
		if (rx_cnt == 0) rx_mode = $urandom_range(0, 2);
		rx_cnt = (rx_cnt + 1) % 64;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic push(input logic [1:0] c, input logic [62:0] t, input logic [31:0] cw,
			input logic [31:0] r, input logic [15:0] m, input logic [15:0] s);
		pend_q.push_back('{c, t, cw, r, m, s});
	endtask

	task automatic drain();
		while (pend_q.size() != 0 || s_tvalid || decision_q.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ENABLE: pace_en = val[0];
			REG_NUM:    gain_num = val[15:0];
			REG_DEN:    gain_den = val[15:0];
			REG_BURST:  burst_pk = val[10:0];
			REG_GRAN:   gran_us = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_all(input logic en, input logic [15:0] nm, input logic [15:0] dn,
			input logic [10:0] bp, input logic [19:0] gr);
		write_reg(REG_ENABLE, 20'(en));
		write_reg(REG_NUM, 20'(nm));
		write_reg(REG_DEN, 20'(dn));
		write_reg(REG_BURST, 20'(bp));
		write_reg(REG_GRAN, gr);
	endtask

	// mostly well-formed traffic: mostly advancing clock, random mix of checks, sends, clears and unused commands
	task automatic traffic(input int n);
		logic [62:0] t;
		logic [31:0] cw, r;
		logic [15:0] m;
		int k;
		t = 63'($urandom_range(0, 1_000_000));
		m = 16'd1500; cw = 32'd15000; r = 32'd50;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 31) == 0) begin
				case ($urandom_range(0, 3))
					0: m = 16'($urandom);
					1: m = 16'd1200;
					2: m = 16'd9000;
					default: m = 16'd1500;
				endcase
				cw = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300000);
				r = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400);
			end
			k = $urandom_range(0, 99);
			if (k < 3) t = t - 63'($urandom_range(0, 5000));
			else if (k < 6) t = 63'(rnd64());
			else if (k < 12) t = t + 63'({$urandom_range(0, 7), $urandom});
			else if (k < 90) t = t + 63'($urandom_range(0, 3_000_000));
			k = $urandom_range(0, 99);
			if (k < 55) push(CMD_CHECK, t, cw, r, m, 16'($urandom));
			else if (k < 92) push(CMD_SENT, t, $urandom, $urandom,
				16'($urandom), ($urandom_range(0, 3) == 0) ? 16'($urandom) : m);
			else if (k < 95) push(CMD_CLEAR, 63'(rnd64()), $urandom, $urandom,
				16'($urandom), 16'($urandom));
			else if (k < 97) push(CMD_UNUSED, 63'(rnd64()), $urandom, $urandom,
				16'($urandom), 16'($urandom));
			else push(CMD_CHECK, 63'(rnd64()), $urandom, $urandom,
				16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: first check, drain, stalled clock, odd commands, extremes
		push(CMD_SENT, 63'd10, '0, '0, '0, 16'd500);
		push(CMD_CHECK, 63'd1000, 32'd15000, 32'd50, 16'd1500, '0);
		for (int i = 0; i < 10; i++) push(CMD_SENT, 63'd1000, '0, '0, '0, 16'd1500);
		push(CMD_CHECK, 63'd1000, 32'd15000, 32'd50, 16'd1500, '0);
		push(CMD_CHECK, 63'd500, 32'd15000, 32'd50, 16'd1500, '0);
		push(CMD_SENT, 63'd600, '0, '0, '0, 16'd0);
		push(CMD_UNUSED, MAX63, '1, '1, '1, '1);
		push(CMD_CHECK, 63'd9_000_000, 32'd0, 32'd0, 16'd0, '0);
		push(CMD_CHECK, 63'd9_500_000, '1, '1, '1, '1);
		push(CMD_CLEAR, '0, '0, '0, '0, '0);
		push(CMD_SENT, 63'd5, '0, '0, '0, 16'hFFFF);
		push(CMD_CHECK, MAX63 - 63'd10, 32'd3000, 32'd60000, 16'd1500, '0);
		push(CMD_SENT, MAX63, '0, '0, '0, 16'hFFFF);
		push(CMD_CHECK, MAX63, 32'd3000, 32'd60001, 16'd1500, '0);
		push(CMD_CLEAR, '0, '0, '0, '0, '0);
		drain();

		traffic(250);
		drain();
		set_all(1'b1, 16'hFFFF, 16'd1, 11'd1024, 20'd0);
		traffic(250);
		drain();
		set_all(1'b1, 16'd1, 16'hFFFF, 11'd0, 20'd1_000_000);
		traffic(200);
		drain();
		set_all(1'b1, 16'd0, 16'd0, 11'd3, 20'd1);
		traffic(150);
		drain();
		set_all(1'b0, 16'd5, 16'd4, 11'd10, 20'd1000);
		traffic(150);
		drain();
		for (int p = 0; p < 4; p++) begin
			set_all(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				11'($urandom_range(0, 1024)), 20'($urandom_range(0, 1_000_000)));
			traffic(200);
			drain();
		end
		set_all(1'b1, 16'd5, 16'd4, 11'd10, 20'd1000);
		traffic(100);
		drain();

		$display("run covered %0d commands, %0d checks (%0d granted, %0d deferred)",
			n_cmds, n_checks, n_grants, n_waits);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/pptb_pkg.sv
hw/rtl/packet_pacer_token_bucket.sv
tb/packet_pacer_token_bucket_tb.sv
